/* rtl/tfs_pkg.sv */
package tfs_pkg;

  localparam int ANGLE_BITS_DEF = 32;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int REM_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHOT_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_MARGIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_TICKS  = 3'd5;

  localparam logic [15:0] SHOT_STEP_RST    = 16'd36864;
  localparam logic [9:0]  BURST_PERIOD_RST = 10'd80;
  localparam logic [9:0]  HOLD_TICKS_RST   = 10'd100;
  localparam logic [15:0] JAM_MARGIN_RST   = 16'd5000;
  localparam logic [11:0] JAM_TICKS_RST    = 12'd900;
  localparam logic [15:0] CALIB_TICKS_RST  = 16'd5000;

  localparam logic [1:0] SW_UP   = 2'd1;
  localparam logic [1:0] SW_DOWN = 2'd2;

  localparam logic [REM_W-1:0] SLOT_MOD = 16'd36864;

  localparam logic [12:0] BLOCKED_MAX = 13'd8191;

  localparam logic [7:0]  LIMIT_MID  = 8'd18;
  localparam logic [7:0]  LIMIT_HIGH = 8'd30;
  localparam logic [12:0] RPM_LOW    = 13'd4500;
  localparam logic [12:0] RPM_MID    = 13'd5400;
  localparam logic [12:0] RPM_HIGH   = 13'd7900;
  localparam logic [12:0] RPM_OFF    = 13'd0;

  typedef struct packed {
    logic load;
    logic step;
  } tfs_div_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_DONE = 5'b10000
  } tfs_state_t;

  function automatic logic [12:0] rpm_for(input logic [7:0] limit);
    logic [12:0] rpm;
    case (limit)
      LIMIT_MID:  rpm = RPM_MID;
      LIMIT_HIGH: rpm = RPM_HIGH;
      default:    rpm = RPM_LOW;
    endcase
    return rpm;
  endfunction

endpackage

/* rtl/tfs_serial_rem.sv */
module tfs_serial_rem #(
  parameter int ANGLE_BITS = tfs_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  tfs_pkg::tfs_div_ctl_t        ctl,
  input  logic [ANGLE_BITS-1:0]        dividend,
  input  logic [tfs_pkg::REM_W-1:0]    divisor,
  output logic [tfs_pkg::REM_W-1:0]    remainder
);
  import tfs_pkg::*;

  logic [ANGLE_BITS-1:0] dvd_r;
  logic [REM_W-1:0]      rem_r;
  logic [REM_W-1:0]      rem_nxt;
  logic [REM_W:0]        trial;

  // restoring step, dividend enters MSB first
  always_comb begin
    trial = {rem_r, dvd_r[ANGLE_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = REM_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (ctl.step) begin
      dvd_r <= {dvd_r[ANGLE_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign remainder = rem_r;

endmodule

/* rtl/trigger_feed_sequencer_top.sv */
// A request steps through ADD, DIV, FIX and DONE; its result is then registered at the outputs with out_valid.
// No new request is taken until the sequencer is back in IDLE; the time per request is set by the
// LSB-first serial adders (two passes) and the one-bit-per-cycle remainder units in between.
// A finished result waits in the output register while the next request is taken.
// Reset: synchronous, active low; config returns to defaults, mode stopped, target zero.
module trigger_feed_sequencer_top #(
  parameter int ANGLE_BITS = tfs_pkg::ANGLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tfs_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_left_switch,
  input  logic [1:0]                       in_right_switch,
  input  logic                             in_fire_key,
  input  logic                             in_mouse_left,
  input  logic signed [31:0]               in_trigger_angle,
  input  logic [7:0]                       in_speed_limit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_armed,
  output logic signed [31:0]               out_position_target,
  output logic                             out_drive_enable,
  output logic [12:0]                      out_wheel_rpm,
  output logic                             out_jam_recovered
);
  import tfs_pkg::*;

  localparam int W     = ANGLE_BITS;
  localparam int CNT_W = $clog2(ANGLE_BITS + 2);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(ANGLE_BITS - 1);
  localparam logic [CNT_W-1:0] SIGN_POS = CNT_W'(ANGLE_BITS);
  localparam logic [CNT_W-1:0] LAST_ADD = CNT_W'(ANGLE_BITS + 1);

  // config
  logic [15:0] shot_step_r;
  logic [9:0]  burst_period_r;
  logic [9:0]  hold_ticks_r;
  logic [15:0] jam_margin_r;
  logic [11:0] jam_ticks_r;
  logic [15:0] calib_ticks_r;

  // tick state
  logic               mode_r;
  logic signed [W-1:0] tgt_r;
  logic signed [16:0] sp_r;
  logic [1:0]         prev_left_r;
  logic               prev_key_r;
  logic               prev_mouse_r;
  logic [10:0]        hold_cnt_r;
  logic               hold_act_r;
  logic [9:0]         burst_cnt_r;
  logic [12:0]        blk_cnt_r;
  logic [15:0]        calib_cnt_r;

  // sequencer
  tfs_state_t         state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;

  // request payload and serial datapath
  logic signed [W-1:0] ang_r;
  logic [12:0]        rpm_r;
  logic               force_r;
  logic [W-1:0]       tgt_sr;
  logic [16:0]        sub_sr;
  logic [15:0]        mar_sr;
  logic [W-1:0]       ang_sr;
  logic [16:0]        sp_sr;
  logic [W-1:0]       res_sr;
  logic [W-1:0]       xs_sr;
  logic [W-1:0]       nxs_sr;
  logic [W-1:0]       nang_sr;
  logic [W-1:0]       jt_sr;
  logic [16:0]        r_sr;
  logic               c1_r;
  logic [1:0]         c2_r;
  logic               c3_r;
  logic               c4_r;
  logic               c5_r;
  logic               xsign_r;
  logic               blocked_r;

  logic               out_armed_r;
  logic signed [31:0] out_tgt_r;
  logic               out_drive_r;
  logic [12:0]        out_rpm_r;
  logic               out_rec_r;

  // per-request control logic
  logic        accept;
  logic        up_edge, key_edge, down_edge, click;
  logic        mode_nxt;
  logic [10:0] hold_inc, hold_cnt_nxt;
  logic        hold_act_nxt;
  logic [10:0] burst_inc;
  logic [9:0]  burst_cnt_nxt;
  logic        burst_shot, edge_shot;
  logic [16:0] sub_nxt;
  logic        calib_now, stop_hold;
  logic [15:0] calib_cnt_nxt;

  // serial bit slices
  logic        lo_half;
  logic [1:0]  s1_sum;
  logic        s1_bit;
  logic [2:0]  s2_sum;
  logic [1:0]  x_sum, nx_sum, na_sum, jt_sum;

  // remainder units
  tfs_div_ctl_t      div_ctl;
  logic [W-1:0]      jam_dvd, slot_dvd;
  logic [REM_W-1:0]  jam_rem, slot_rem;
  logic [16:0]       jam_rpos, slot_rpos;
  logic [16:0]       r_val;
  logic signed [16:0] sp_new;

  // finish
  logic               can_load;
  logic [12:0]        blk_inc, blk_cnt_nxt;
  logic               recovered;
  logic signed [W-1:0] snap_tgt, tgt_fin;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign can_load = !out_valid_r || !out_stall;

  always_comb begin
    up_edge   = (in_left_switch == SW_UP) && (prev_left_r != SW_UP);
    key_edge  = in_fire_key && !prev_key_r;
    mode_nxt  = mode_r ^ (up_edge || key_edge);
    down_edge = (in_left_switch == SW_DOWN) && (prev_left_r != SW_DOWN);
    click     = in_mouse_left && !prev_mouse_r;

    hold_inc     = hold_cnt_r + 11'd1;
    hold_cnt_nxt = '0;
    hold_act_nxt = 1'b0;
    if (in_mouse_left) begin
      if (hold_inc >= {1'b0, hold_ticks_r}) begin
        hold_cnt_nxt = {1'b0, hold_ticks_r} + 11'd1;
        hold_act_nxt = 1'b1;
      end else begin
        hold_cnt_nxt = hold_inc;
        hold_act_nxt = hold_act_r;
      end
    end

    burst_inc     = {1'b0, burst_cnt_r} + 11'd1;
    burst_cnt_nxt = burst_cnt_r;
    burst_shot    = 1'b0;
    if (hold_act_nxt && mode_nxt) begin
      if (burst_inc >= {1'b0, burst_period_r}) begin
        burst_shot    = 1'b1;
        burst_cnt_nxt = '0;
      end else begin
        burst_cnt_nxt = burst_inc[9:0];
      end
    end

    edge_shot = mode_nxt && (down_edge || click);
    case ({edge_shot, burst_shot})
      2'b11:   sub_nxt = {shot_step_r, 1'b0};
      2'b00:   sub_nxt = '0;
      default: sub_nxt = {1'b0, shot_step_r};
    endcase

    calib_now     = calib_cnt_r < calib_ticks_r;
    calib_cnt_nxt = calib_now ? calib_cnt_r + 16'd1 : calib_cnt_r;
    stop_hold     = !mode_nxt &&
                    ((in_left_switch == SW_DOWN) || (in_right_switch == SW_DOWN));
  end

  // LSB-first pass: shots, jam compare, angle - slot_phase and its negation, -angle
  always_comb begin
    lo_half = cnt_r < SIGN_POS;
    s1_sum  = {1'b0, tgt_sr[0]} + {1'b0, ~sub_sr[0]} + {1'b0, c1_r};
    s1_bit  = lo_half ? s1_sum[0] : res_sr[W-1];
    s2_sum  = {2'b0, s1_bit} + {2'b0, mar_sr[0]} + {2'b0, ~ang_sr[0]} + {1'b0, c2_r};
    x_sum   = {1'b0, ang_sr[0]} + {1'b0, ~sp_sr[0]} + {1'b0, c3_r};
    nx_sum  = {1'b0, sp_sr[0]} + {1'b0, ~ang_sr[0]} + {1'b0, c4_r};
    na_sum  = {1'b0, ~ang_sr[0]} + {1'b0, c5_r};
    jt_sum  = {1'b0, ang_sr[0]} + {1'b0, ~r_sr[0]} + {1'b0, c1_r};
  end

  always_comb begin
    div_ctl.load = (state_r == ST_ADD) && (cnt_r == LAST_ADD);
    div_ctl.step = (state_r == ST_DIV) && (cnt_r != SIGN_POS);
    jam_dvd      = xsign_r ? nxs_sr : xs_sr;
    slot_dvd     = ang_r[W-1] ? nang_sr : ang_r;
    jam_rpos     = {1'b0, jam_rem};
    slot_rpos    = {1'b0, slot_rem};
    r_val        = xsign_r ? 17'd0 - jam_rpos : jam_rpos;
    sp_new       = ang_r[W-1] ? 17'd0 - slot_rpos : slot_rpos;
  end

  tfs_serial_rem #(.ANGLE_BITS(ANGLE_BITS)) u_jam_rem (
    .clk       (clk),
    .ctl       (div_ctl),
    .dividend  (jam_dvd),
    .divisor   (shot_step_r),
    .remainder (jam_rem)
  );

  tfs_serial_rem #(.ANGLE_BITS(ANGLE_BITS)) u_slot_rem (
    .clk       (clk),
    .ctl       (div_ctl),
    .dividend  (slot_dvd),
    .divisor   (SLOT_MOD),
    .remainder (slot_rem)
  );

  // snapped target is angle minus the signed jam remainder, or the slot phase when shot_step is zero
  always_comb begin
    if (!blocked_r) begin
      blk_inc = '0;
    end else if (blk_cnt_r == BLOCKED_MAX) begin
      blk_inc = blk_cnt_r;
    end else begin
      blk_inc = blk_cnt_r + 13'd1;
    end
    recovered   = blk_inc > {1'b0, jam_ticks_r};
    blk_cnt_nxt = recovered ? '0 : blk_inc;
    snap_tgt    = (shot_step_r == '0) ? W'(sp_r) : jt_sr;
    if (force_r) begin
      tgt_fin = ang_r;
    end else if (recovered) begin
      tgt_fin = snap_tgt;
    end else begin
      tgt_fin = res_sr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shot_step_r    <= SHOT_STEP_RST;
      burst_period_r <= BURST_PERIOD_RST;
      hold_ticks_r   <= HOLD_TICKS_RST;
      jam_margin_r   <= JAM_MARGIN_RST;
      jam_ticks_r    <= JAM_TICKS_RST;
      calib_ticks_r  <= CALIB_TICKS_RST;
      mode_r         <= 1'b0;
      tgt_r          <= '0;
      sp_r           <= '0;
      prev_left_r    <= SW_UP;
      prev_key_r     <= 1'b0;
      prev_mouse_r   <= 1'b0;
      hold_cnt_r     <= '0;
      hold_act_r     <= 1'b0;
      burst_cnt_r    <= '0;
      blk_cnt_r      <= '0;
      calib_cnt_r    <= '0;
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SHOT_STEP:    shot_step_r    <= cfg_data;
          CFG_BURST_PERIOD: burst_period_r <= cfg_data[9:0];
          CFG_HOLD_TICKS:   hold_ticks_r   <= cfg_data[9:0];
          CFG_JAM_MARGIN:   jam_margin_r   <= cfg_data;
          CFG_JAM_TICKS:    jam_ticks_r    <= cfg_data[11:0];
          CFG_CALIB_TICKS:  calib_ticks_r  <= cfg_data;
          default: ;
        endcase
      end

      if ((state_r == ST_DONE) && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mode_r       <= mode_nxt;
            prev_left_r  <= in_left_switch;
            prev_key_r   <= in_fire_key;
            prev_mouse_r <= in_mouse_left;
            hold_cnt_r   <= hold_cnt_nxt;
            hold_act_r   <= hold_act_nxt;
            burst_cnt_r  <= burst_cnt_nxt;
            calib_cnt_r  <= calib_cnt_nxt;
            cnt_r        <= '0;
            state_r      <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (cnt_r == LAST_ADD) begin
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_DIV: begin
          if (cnt_r == SIGN_POS) begin
            cnt_r   <= '0;
            state_r <= ST_FIX;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_FIX: begin
          if (cnt_r == LAST_BIT) begin
            cnt_r   <= '0;
            state_r <= ST_DONE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (can_load) begin
            tgt_r     <= tgt_fin;
            blk_cnt_r <= blk_cnt_nxt;
            if (force_r) begin
              sp_r <= sp_new;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ang_r   <= in_trigger_angle[W-1:0];
          ang_sr  <= in_trigger_angle[W-1:0];
          tgt_sr  <= tgt_r;
          sub_sr  <= sub_nxt;
          mar_sr  <= jam_margin_r;
          sp_sr   <= sp_r;
          rpm_r   <= mode_nxt ? rpm_for(in_speed_limit) : RPM_OFF;
          force_r <= calib_now || stop_hold;
          c1_r    <= 1'b1;
          c2_r    <= 2'd1;
          c3_r    <= 1'b1;
          c4_r    <= 1'b1;
          c5_r    <= 1'b1;
        end
      end
      ST_ADD: begin
        tgt_sr <= {tgt_sr[W-1], tgt_sr[W-1:1]};
        sub_sr <= {1'b0, sub_sr[16:1]};
        mar_sr <= {1'b0, mar_sr[15:1]};
        ang_sr <= {ang_sr[W-1], ang_sr[W-1:1]};
        sp_sr  <= {sp_sr[16], sp_sr[16:1]};
        c1_r   <= s1_sum[1];
        c2_r   <= s2_sum[2:1];
        c3_r   <= x_sum[1];
        c4_r   <= nx_sum[1];
        c5_r   <= na_sum[1];
        if (lo_half) begin
          res_sr  <= {s1_sum[0], res_sr[W-1:1]};
          xs_sr   <= {x_sum[0], xs_sr[W-1:1]};
          nxs_sr  <= {nx_sum[0], nxs_sr[W-1:1]};
          nang_sr <= {na_sum[0], nang_sr[W-1:1]};
        end
        if (cnt_r == SIGN_POS) begin
          xsign_r <= x_sum[0];
        end
        if (cnt_r == LAST_ADD) begin
          blocked_r <= s2_sum[0];
        end
      end
      ST_DIV: begin
        if (cnt_r == SIGN_POS) begin
          ang_sr <= ang_r;
          r_sr   <= r_val;
          c1_r   <= 1'b1;
        end
      end
      ST_FIX: begin
        ang_sr <= {ang_sr[W-1], ang_sr[W-1:1]};
        r_sr   <= {r_sr[16], r_sr[16:1]};
        c1_r   <= jt_sum[1];
        jt_sr  <= {jt_sum[0], jt_sr[W-1:1]};
      end
      ST_DONE: begin
        if (can_load) begin
          out_armed_r <= mode_r;
          out_tgt_r   <= 32'(tgt_fin);
          out_drive_r <= !force_r;
          out_rpm_r   <= rpm_r;
          out_rec_r   <= recovered;
        end
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_armed           = out_armed_r;
  assign out_position_target = out_tgt_r;
  assign out_drive_enable    = out_drive_r;
  assign out_wheel_rpm       = out_rpm_r;
  assign out_jam_recovered   = out_rec_r;

endmodule
